>>> rtl/core/zsrf_pkg.sv
// ----------------------------------------------------------------------------
// Zero-sentinel ring FIFO package
// Shared constants, request codes and control types for the FIFO block.
// ----------------------------------------------------------------------------
package zsrf_pkg;

  // Default number of physical slots in the slot memory.
  localparam int MAX_SLOTS_DEFAULT = 256;

  // Field widths fixed by the interface.
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int QSIZE_W = 9;

  // Queue size after reset.
  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 9'd256;

  // Request codes. Code 3 is unused; it returns a result with zero data, stored low.
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAN = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_t;

  // Commands from the controller to the pointer unit.
  typedef struct packed {
    logic clear;
    logic adv_rd;
    logic adv_wr;
  } ptr_ctrl_t;

endpackage

>>> rtl/core/zsrf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module zsrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/zsrf_ptr.sv
// ----------------------------------------------------------------------------
// Zero-sentinel ring FIFO pointer unit
// Holds the read and write pointers, advances them with wrap at the active
// size and reports whether each pointer lies inside the active size.
// ----------------------------------------------------------------------------
module zsrf_ptr
  import zsrf_pkg::*;
#(
  parameter int PTR_W  = 8,
  parameter int SIZE_W = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  ptr_ctrl_t         ctrl,
  input  logic [SIZE_W-1:0] size,
  output logic [PTR_W-1:0]  rd_ptr,
  output logic [PTR_W-1:0]  wr_ptr,
  output logic              rd_ok,
  output logic              wr_ok
);

  logic [PTR_W:0]   rd_inc;
  logic [PTR_W:0]   wr_inc;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr_next;

  // Range checks against the active size.
  assign rd_ok = SIZE_W'(rd_ptr) < size;
  assign wr_ok = SIZE_W'(wr_ptr) < size;

  // Advance with wrap: the incremented pointer wraps to zero at the size.
  always_comb begin
    rd_inc      = {1'b0, rd_ptr} + 1'b1;
    wr_inc      = {1'b0, wr_ptr} + 1'b1;
    rd_ptr_next = (SIZE_W'(rd_inc) < size) ? rd_inc[PTR_W-1:0] : '0;
    wr_ptr_next = (SIZE_W'(wr_inc) < size) ? wr_inc[PTR_W-1:0] : '0;
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      if (ctrl.adv_rd) begin
        rd_ptr <= rd_ptr_next;
      end
      if (ctrl.adv_wr) begin
        wr_ptr <= wr_ptr_next;
      end
    end
  end

endmodule

>>> rtl/core/zero_sentinel_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// Zero-sentinel ring FIFO
// Add and take go through a slot memory read, then a check of the word and its
// write-back, which also loads the result register. A new word is not
// accepted until the last one is through and the output register is free.
// A clean sweeps all MAX_SLOTS slots, one a cycle, then gives its result.
// After reset the same sweep runs with in_stall high.
// ----------------------------------------------------------------------------
module zero_sentinel_ring_fifo_unit
  import zsrf_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [QSIZE_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [DATA_W-1:0]  data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  read_data,
  output logic               stored
);

  localparam int PTR_W  = $clog2(MAX_SLOTS);
  localparam int SIZE_W = (QSIZE_W > PTR_W + 1) ? QSIZE_W : PTR_W + 1;
  localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(MAX_SLOTS - 1);
  localparam logic [SIZE_W-1:0] MAX_SIZE  = SIZE_W'(MAX_SLOTS);

  state_t              state;
  state_t              state_next;
  logic [QSIZE_W-1:0]  queue_size;
  logic [REQ_W-1:0]    req_q;
  logic [DATA_W-1:0]   data_q;
  logic [PTR_W-1:0]    clr_cnt;
  logic                clean_pend;
  logic [SIZE_W-1:0]   size_ext;
  logic [SIZE_W-1:0]   eff_size;
  logic                accept;
  logic                out_free;
  logic                load_out;
  logic [DATA_W-1:0]   load_rd;
  logic                load_st;
  ptr_ctrl_t           pctrl;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W-1:0]    wr_ptr;
  logic                rd_ok;
  logic                wr_ok;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;
  logic [PTR_W-1:0]    mem_raddr;
  logic [DATA_W-1:0]   mem_rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_size <= QSIZE_RESET;
    end else if (cfg_wr_en) begin
      queue_size <= cfg_wr_data;
    end
  end

  // Active size: the register limited to the physical slot count.
  assign size_ext = SIZE_W'(queue_size);
  assign eff_size = (size_ext > MAX_SIZE) ? MAX_SIZE : size_ext;

  // Input handshake: one word in flight, and the output register must be free.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Read address is chosen from the incoming request.
  assign mem_raddr = (req_type == REQ_TAKE) ? rd_ptr : wr_ptr;

  // Controller: state step, memory write, pointer commands and result load.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt;
    mem_wdata  = '0;
    pctrl      = '0;
    load_out   = 1'b0;
    load_rd    = '0;
    load_st    = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_cnt == LAST_SLOT) begin
          pctrl.clear = 1'b1;
          load_out    = clean_pend;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_CLEAN) begin
            state_next = ST_CLEAR;
          end else if (req_type == REQ_ADD || req_type == REQ_TAKE) begin
            state_next = ST_READ;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_READ: begin
        load_out   = 1'b1;
        state_next = ST_IDLE;
        if (req_q == REQ_ADD) begin
          if (wr_ok && mem_rdata == '0) begin
            mem_we       = 1'b1;
            mem_waddr    = wr_ptr;
            mem_wdata    = data_q;
            pctrl.adv_wr = 1'b1;
            load_st      = 1'b1;
          end
        end else if (rd_ok) begin
          load_rd = mem_rdata;
          if (mem_rdata != '0) begin
            mem_we       = 1'b1;
            mem_waddr    = rd_ptr;
            pctrl.adv_rd = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clean_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == LAST_SLOT) begin
          clean_pend <= 1'b0;
        end
      end else if (accept && req_type == REQ_CLEAN) begin
        clr_cnt    <= '0;
        clean_pend <= 1'b1;
      end
    end
  end

  // Latched request payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req_type;
      data_q <= data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_data <= load_rd;
      stored    <= load_st;
    end
  end

  // Pointer unit.
  zsrf_ptr #(
    .PTR_W  (PTR_W),
    .SIZE_W (SIZE_W)
  ) u_ptr (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (pctrl),
    .size   (eff_size),
    .rd_ptr (rd_ptr),
    .wr_ptr (wr_ptr),
    .rd_ok  (rd_ok),
    .wr_ok  (wr_ok)
  );

  // Slot memory.
  zsrf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The controller is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");

  // A read-modify-write never finds the output register occupied.
  a_read_out_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !out_valid)
    else $error("output register busy during slot update");

  // A word is either stored by an add or returned by a take, never both.
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stored && read_data != '0))
    else $error("result reports both a store and a taken word");

endmodule
